// ===== rtl/ttw_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Text terminal writer package
// Shared request, result, command and register types with fixed constants.
// ----------------------------------------------------------------------------
package ttw_pkg;

  localparam int POS_W       = 9;
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 8;
  localparam int CMD_DEPTH   = 4;
  localparam int RES_DEPTH   = 2;

  localparam logic [CFG_INDEX_W-1:0] REG_COLUMNS    = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ROWS       = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_FORE_COLOR = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_BACK_COLOR = 8'd3;

  localparam logic [7:0] RESET_COLUMNS    = 8'd80;
  localparam logic [5:0] RESET_ROWS       = 6'd25;
  localparam logic [3:0] RESET_FORE_COLOR = 4'd7;
  localparam logic [3:0] RESET_BACK_COLOR = 4'd0;

  localparam logic [7:0]  CHAR_NUL   = 8'h00;
  localparam logic [7:0]  CHAR_TAB   = 8'h09;
  localparam logic [7:0]  CHAR_LF    = 8'h0a;
  localparam logic [7:0]  CHAR_CR    = 8'h0d;
  localparam logic [15:0] FILL_BLANK = 16'h0700;

  typedef enum logic [1:0] {
    FUNC_WRITE,
    FUNC_SETPOS,
    FUNC_CLEAR,
    FUNC_READ
  } func_t;

  typedef enum logic [2:0] {
    KIND_NOP,
    KIND_TAB,
    KIND_NEWLINE,
    KIND_RETURN,
    KIND_PRINT,
    KIND_SETPOS,
    KIND_CLEAR,
    KIND_READ
  } kind_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_PUT,
    ST_CHECK,
    ST_SCROLL,
    ST_FILL,
    ST_REPORT
  } state_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  char_code;
    logic [7:0]  new_col;
    logic [7:0]  new_row;
    logic [11:0] cell_index;
  } item_t;

  typedef struct packed {
    logic [7:0]  cur_col;
    logic [7:0]  cur_row;
    logic [15:0] cell_data;
  } result_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  char_code;
    logic [7:0]  new_col;
    logic [7:0]  new_row;
    logic [11:0] cell_index;
  } cmd_t;

  typedef struct packed {
    logic [7:0] columns;
    logic [5:0] rows;
    logic [3:0] fore_color;
    logic [3:0] back_color;
  } cfg_t;

endpackage
`default_nettype wire

// ===== rtl/text_terminal_writer_unit.sv =====
`default_nettype none
// Engine: each request is run to its end before the next is taken from the command queue;
//   clears, scrolls and full blanks make one store access per cycle on the single write port.
// Reset: full stays high while the store is zeroed.
// ----------------------------------------------------------------------------
// Text terminal writer
// Character-cell terminal: front end, command queue, engine and result queue.
// ----------------------------------------------------------------------------
module text_terminal_writer_unit #(
  parameter int MAX_COLUMNS = 128,
  parameter int MAX_ROWS    = 32,
  parameter int TAB_WIDTH   = 4
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               push,
  input  wire ttw_pkg::item_t                     item,
  output logic                                    full,
  input  wire logic                               pop,
  output ttw_pkg::result_t                        result,
  output logic                                    empty,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [ttw_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [ttw_pkg::CFG_DATA_W-1:0]     cfg_data
);

  ttw_pkg::cfg_t    regs;
  ttw_pkg::cmd_t    front_cmd;
  ttw_pkg::cmd_t    queue_cmd;
  ttw_pkg::result_t back_res;
  logic             front_push;
  logic             cmd_full;
  logic             cmd_empty;
  logic             cmd_pop;
  logic             res_push;
  logic             res_full;
  logic             init_busy;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.columns    <= ttw_pkg::RESET_COLUMNS;
      regs.rows       <= ttw_pkg::RESET_ROWS;
      regs.fore_color <= ttw_pkg::RESET_FORE_COLOR;
      regs.back_color <= ttw_pkg::RESET_BACK_COLOR;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ttw_pkg::REG_COLUMNS:    regs.columns    <= cfg_data[7:0];
        ttw_pkg::REG_ROWS:       regs.rows       <= cfg_data[5:0];
        ttw_pkg::REG_FORE_COLOR: regs.fore_color <= cfg_data[3:0];
        ttw_pkg::REG_BACK_COLOR: regs.back_color <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  ttw_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .item     (item),
    .full     (full),
    .hold     (init_busy),
    .cmd      (front_cmd),
    .cmd_push (front_push),
    .cmd_full (cmd_full)
  );

  ttw_queue #(
    .WIDTH ($bits(ttw_pkg::cmd_t)),
    .DEPTH (ttw_pkg::CMD_DEPTH)
  ) u_cmd_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (front_push),
    .wr_data (front_cmd),
    .full    (cmd_full),
    .pop     (cmd_pop),
    .rd_data (queue_cmd),
    .empty   (cmd_empty)
  );

  ttw_back #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS),
    .TAB_WIDTH   (TAB_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .regs      (regs),
    .cmd       (queue_cmd),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .res       (back_res),
    .res_push  (res_push),
    .res_full  (res_full),
    .init_busy (init_busy)
  );

  ttw_queue #(
    .WIDTH ($bits(ttw_pkg::result_t)),
    .DEPTH (ttw_pkg::RES_DEPTH)
  ) u_res_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (res_push),
    .wr_data (back_res),
    .full    (res_full),
    .pop     (pop),
    .rd_data (result),
    .empty   (empty)
  );

endmodule
`default_nettype wire

// ===== rtl/ttw_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Text terminal writer queue
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module ttw_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] rd_data,
  output logic                  empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = slots[rptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      count <= count + CW'(do_push) - CW'(do_pop);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/ttw_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Text terminal writer front end
// Takes requests, sorts them into engine commands and holds one for the queue.
// ----------------------------------------------------------------------------
module ttw_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire ttw_pkg::item_t item,
  output logic               full,
  input  wire logic          hold,
  output ttw_pkg::cmd_t      cmd,
  output logic               cmd_push,
  input  wire logic          cmd_full
);

  logic           vld;
  logic           vld_next;
  logic           accept;
  ttw_pkg::kind_t kind;

  always_comb begin
    kind = ttw_pkg::KIND_NOP;
    case (item.func)
      ttw_pkg::FUNC_WRITE: begin
        if (item.char_code == ttw_pkg::CHAR_NUL) begin
          kind = ttw_pkg::KIND_NOP;
        end else if (item.char_code == ttw_pkg::CHAR_TAB) begin
          kind = ttw_pkg::KIND_TAB;
        end else if (item.char_code == ttw_pkg::CHAR_LF) begin
          kind = ttw_pkg::KIND_NEWLINE;
        end else if (item.char_code == ttw_pkg::CHAR_CR) begin
          kind = ttw_pkg::KIND_RETURN;
        end else begin
          kind = ttw_pkg::KIND_PRINT;
        end
      end
      ttw_pkg::FUNC_SETPOS: kind = ttw_pkg::KIND_SETPOS;
      ttw_pkg::FUNC_CLEAR:  kind = ttw_pkg::KIND_CLEAR;
      ttw_pkg::FUNC_READ:   kind = ttw_pkg::KIND_READ;
      default:              kind = ttw_pkg::KIND_NOP;
    endcase
  end

  assign full     = hold || (vld && cmd_full);
  assign accept   = push && !full;
  assign cmd_push = vld && !cmd_full;

  always_comb begin
    vld_next = vld;
    if (accept) begin
      vld_next = 1'b1;
    end else if (cmd_push) begin
      vld_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else begin
      vld <= vld_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd.kind       <= kind;
      cmd.char_code  <= item.char_code;
      cmd.new_col    <= item.new_col;
      cmd.new_row    <= item.new_row;
      cmd.cell_index <= item.cell_index;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/ttw_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Text terminal writer engine
// Owns the screen store and cursor; runs writes, cursor moves, scrolls,
// clears and reads, and hands the result to the output queue.
// ----------------------------------------------------------------------------
module ttw_back #(
  parameter int MAX_COLUMNS = 128,
  parameter int MAX_ROWS    = 32,
  parameter int TAB_WIDTH   = 4
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire ttw_pkg::cfg_t regs,
  input  wire ttw_pkg::cmd_t cmd,
  input  wire logic          cmd_empty,
  output logic               cmd_pop,
  output ttw_pkg::result_t   res,
  output logic               res_push,
  input  wire logic          res_full,
  output logic               init_busy
);

  localparam int STORE = MAX_COLUMNS * MAX_ROWS;
  localparam int AW    = (STORE > 1) ? $clog2(STORE) : 1;
  localparam int CNT_W = $clog2(STORE + 1);
  localparam int WCW   = $clog2(MAX_COLUMNS + 1);
  localparam int HW    = $clog2(MAX_ROWS + 1);
  localparam int AF_W  = 8 + WCW + 1;
  localparam int PW    = ttw_pkg::POS_W;

  ttw_pkg::state_t state;
  ttw_pkg::state_t state_next;
  ttw_pkg::kind_t  kind;

  logic [WCW-1:0]   w;
  logic [HW-1:0]    h;
  logic [CNT_W-1:0] total;
  logic [CNT_W-1:0] src;
  logic [CNT_W-1:0] dst;
  logic [PW-1:0]    pcol;
  logic [PW-1:0]    prow;
  logic [7:0]       cur_col;
  logic [7:0]       cur_row;
  logic [7:0]       chr;
  logic [AW-1:0]    addr;
  logic             wr_ok;
  logic             rd_ok;
  logic [15:0]      fill_val;
  logic             pend;
  logic [7:0]       attr;
  logic [AF_W-1:0]  addr_full;
  logic [PW-1:0]    h_pos;
  logic [PW-1:0]    lines;
  logic             over;
  logic             fill_all;
  logic [PW-1:0]    tab_stop [256];

  logic [15:0]      mem [STORE];
  logic [15:0]      rdata;
  logic             we;
  logic             ren;
  logic [AW-1:0]    waddr;
  logic [AW-1:0]    raddr;
  logic [15:0]      wdata;

  for (genvar g = 0; g < 256; g++) begin : g_tab
    assign tab_stop[g] = PW'(g + TAB_WIDTH - (g % TAB_WIDTH));
  end

  always_comb begin
    if (regs.columns == 8'd0) begin
      w = WCW'(1);
    end else if (9'(regs.columns) > 9'(MAX_COLUMNS)) begin
      w = WCW'(MAX_COLUMNS);
    end else begin
      w = WCW'(regs.columns);
    end
    if (regs.rows == 6'd0) begin
      h = HW'(1);
    end else if (7'(regs.rows) > 7'(MAX_ROWS)) begin
      h = HW'(MAX_ROWS);
    end else begin
      h = HW'(regs.rows);
    end
  end

  assign attr      = {regs.back_color, regs.fore_color};
  assign addr_full = AF_W'(cur_row) * AF_W'(w) + AF_W'(cur_col);
  assign h_pos     = PW'(h);
  assign over      = (prow >= h_pos);
  assign lines     = prow - h_pos + PW'(1);
  assign fill_all  = (lines >= h_pos - PW'(1));
  assign init_busy = (state == ttw_pkg::ST_INIT);

  assign res.cur_col   = cur_col;
  assign res.cur_row   = cur_row;
  assign res.cell_data = (kind == ttw_pkg::KIND_READ && rd_ok) ? rdata : 16'h0000;

  always_ff @(posedge clk) begin
    total <= CNT_W'(w) * CNT_W'(h);
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ren) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ttw_pkg::ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd_pop    = 1'b0;
    res_push   = 1'b0;
    we         = 1'b0;
    waddr      = dst[AW-1:0];
    wdata      = fill_val;
    ren        = 1'b0;
    raddr      = src[AW-1:0];
    case (state)
      ttw_pkg::ST_INIT: begin
        we    = 1'b1;
        wdata = 16'h0000;
        if (dst == CNT_W'(STORE - 1)) begin
          state_next = ttw_pkg::ST_IDLE;
        end
      end
      ttw_pkg::ST_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop = 1'b1;
          case (cmd.kind)
            ttw_pkg::KIND_READ: begin
              ren        = 1'b1;
              raddr      = AW'(cmd.cell_index);
              state_next = ttw_pkg::ST_REPORT;
            end
            ttw_pkg::KIND_CLEAR:   state_next = ttw_pkg::ST_FILL;
            ttw_pkg::KIND_TAB,
            ttw_pkg::KIND_NEWLINE,
            ttw_pkg::KIND_RETURN,
            ttw_pkg::KIND_PRINT,
            ttw_pkg::KIND_SETPOS:  state_next = ttw_pkg::ST_PUT;
            default:               state_next = ttw_pkg::ST_REPORT;
          endcase
        end
      end
      ttw_pkg::ST_PUT: begin
        we         = wr_ok && (kind == ttw_pkg::KIND_PRINT);
        waddr      = addr;
        wdata      = {attr, chr};
        state_next = ttw_pkg::ST_CHECK;
      end
      ttw_pkg::ST_CHECK: begin
        if (over) begin
          state_next = fill_all ? ttw_pkg::ST_FILL : ttw_pkg::ST_SCROLL;
        end else begin
          state_next = ttw_pkg::ST_REPORT;
        end
      end
      ttw_pkg::ST_SCROLL: begin
        ren   = (src < total);
        we    = pend;
        wdata = rdata;
        if (!ren && !pend) begin
          state_next = ttw_pkg::ST_FILL;
        end
      end
      ttw_pkg::ST_FILL: begin
        if (dst < total) begin
          we = 1'b1;
        end else begin
          state_next = ttw_pkg::ST_REPORT;
        end
      end
      ttw_pkg::ST_REPORT: begin
        res_push = !res_full;
        if (!res_full) begin
          state_next = ttw_pkg::ST_IDLE;
        end
      end
      default: state_next = ttw_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_col <= 8'd0;
      cur_row <= 8'd0;
      dst     <= '0;
      pend    <= 1'b0;
    end else begin
      case (state)
        ttw_pkg::ST_INIT: begin
          dst <= dst + 1'b1;
        end
        ttw_pkg::ST_IDLE: begin
          if (!cmd_empty) begin
            kind  <= cmd.kind;
            chr   <= cmd.char_code;
            addr  <= addr_full[AW-1:0];
            wr_ok <= (addr_full < AF_W'(STORE));
            rd_ok <= (32'(cmd.cell_index) < 32'(STORE));
            dst   <= '0;
            case (cmd.kind)
              ttw_pkg::KIND_TAB: begin
                pcol <= tab_stop[cur_col];
                prow <= PW'(cur_row);
              end
              ttw_pkg::KIND_NEWLINE: begin
                pcol <= '0;
                prow <= PW'(cur_row) + PW'(1);
              end
              ttw_pkg::KIND_RETURN: begin
                pcol <= '0;
                prow <= PW'(cur_row);
              end
              ttw_pkg::KIND_PRINT: begin
                pcol <= PW'(cur_col) + PW'(1);
                prow <= PW'(cur_row);
              end
              ttw_pkg::KIND_SETPOS: begin
                pcol <= PW'(cmd.new_col);
                prow <= PW'(cmd.new_row);
              end
              default: begin
                pcol     <= '0;
                prow     <= '0;
                fill_val <= {attr, 8'h00};
              end
            endcase
          end
        end
        ttw_pkg::ST_PUT: begin
          if (pcol >= PW'(w)) begin
            pcol <= '0;
            prow <= prow + PW'(1);
          end
        end
        ttw_pkg::ST_CHECK: begin
          if (over) begin
            dst  <= '0;
            pend <= 1'b0;
            if (fill_all) begin
              fill_val <= ttw_pkg::FILL_BLANK;
              pcol     <= '0;
              prow     <= '0;
            end else begin
              src  <= CNT_W'(w) * CNT_W'(lines);
              prow <= prow - lines;
            end
          end else begin
            cur_col <= pcol[7:0];
            cur_row <= prow[7:0];
          end
        end
        ttw_pkg::ST_SCROLL: begin
          if (ren) begin
            src <= src + 1'b1;
          end
          if (pend) begin
            dst <= dst + 1'b1;
          end
          pend <= ren;
          if (!ren && !pend) begin
            fill_val <= 16'h0000;
          end
        end
        ttw_pkg::ST_FILL: begin
          if (dst < total) begin
            dst <= dst + 1'b1;
          end else begin
            cur_col <= pcol[7:0];
            cur_row <= prow[7:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/ttw_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Text terminal writer checker
// Port-level checks on reset behaviour, result holding and request balance.
// ----------------------------------------------------------------------------
module ttw_checker (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             push,
  input wire logic             full,
  input wire logic             pop,
  input wire logic             empty,
  input wire ttw_pkg::result_t result
);

  logic [3:0] outstanding;

  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= 4'd0;
    end else begin
      outstanding <= outstanding + 4'(push && !full) - 4'(pop && !empty);
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  a_reset_full: assert property (@(posedge clk) rst |=> full)
    else $error("request taken during store clearing");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("waiting result changed or vanished");

  a_no_extra_result: assert property (@(posedge clk) disable iff (rst)
    (!empty) |-> (outstanding != 4'd0))
    else $error("result shown with no request outstanding");

endmodule

bind text_terminal_writer_unit ttw_checker u_checker (.*);
`default_nettype wire
